// ===== rtl/core/bst_pkg.sv =====
package bst_pkg;

  // Default longest token or string, counting the slot that forces the cut.
  localparam int unsigned MAX_LEN_DEF = 256;

  // Results one input item can cause, and entries in the front-to-back queue.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_END     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Result kinds.
  typedef enum logic [2:0] {
    K_TCHAR = 3'd0,
    K_SCHAR = 3'd1,
    K_TEND  = 3'd2,
    K_SEND  = 3'd3,
    K_IEND  = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_COMMENT_CHAR  = 1'b0,
    REG_DOS_LINE_ENDS = 1'b1
  } reg_e;

  // Character codes the lexer tests for.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  // One result as it leaves the block (the line number is shared per item).
  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_value;
    logic       truncated;
  } res_t;

  // All results of one input item, as one queue entry.
  typedef struct packed {
    logic [1:0]               count;
    res_t [MAX_RES-1:0]       res;
    logic [15:0]              line_number;
  } entry_t;

endpackage

// ===== rtl/core/byte_stream_tokenizer.sv =====
// A result is registered in the queue on the transfer of the item that causes it.
// Throughput: one input item per cycle while the queue is not full; the results of an
// item leave one per output transfer, and the four-entry queue between lexer and output
// lets the input run ahead. Reset: lexer between tokens at line one, input not ended,
// both registers zero and the queue empty; there is no clearing pass.
module byte_stream_tokenizer #(
  parameter int unsigned MAX_LEN = bst_pkg::MAX_LEN_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] char_value, [8] truncated, [24:9] line_number
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);
  import bst_pkg::*;

  logic   push, pop, full, empty;
  entry_t push_entry, head;

  bst_lexer #(
    .MAX_LEN(MAX_LEN)
  ) u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .full_i      (full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  bst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  bst_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== rtl/core/bst_lexer.sv =====
module bst_lexer #(
  parameter int unsigned MAX_LEN = bst_pkg::MAX_LEN_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_addr_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      in_cmd_i,
  input  logic [7:0]      in_byte_i,
  input  logic            full_i,
  output logic            push_o,
  output bst_pkg::entry_t push_entry_o
);
  import bst_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LEN);
  localparam logic [LenW-1:0] LenLimit = LenW'(MAX_LEN - 1);

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_TOKEN   = 8'b0000_0100,
    M_STRING  = 8'b0000_1000,
    M_ESC     = 8'b0001_0000,
    M_HEX     = 8'b0010_0000,
    M_OCT     = 8'b0100_0000,
    M_SKIP    = 8'b1000_0000
  } mode_e;

  typedef enum logic [2:0] {
    C_FLUSH = 3'd0,
    C_WHITE = 3'd1,
    C_QUOTE = 3'd2,
    C_BREAK = 3'd3,
    C_TOKEN = 3'd4
  } cls_e;

  typedef struct packed {
    mode_e           mode;
    logic [7:0]      quote;
    logic [LenW-1:0] len;
    logic [7:0]      esc_val;
    logic [1:0]      esc_dig;
  } lex_st_t;

  // Outcome of lexing one byte once in one mode.
  typedef struct packed {
    lex_st_t    st;
    logic       again;
    logic [1:0] n;
    res_t [1:0] r;
  } pass_t;

  // Byte class by the fixed table on the low seven bits.
  function automatic cls_e byte_class(logic [7:0] c);
    logic [6:0] v;
    v = c[6:0];
    if (v == 7'h7F || v < 7'd8 || (v >= 7'd14 && v < 7'd32)) return C_FLUSH;
    if (v < 7'd14 || v == 7'd32) return C_WHITE;
    if (v == 7'd34 || v == 7'd39) return C_QUOTE;
    if (v == 7'd44) return C_BREAK;
    return C_TOKEN;
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'd32 : c;
  endfunction

  // Letter escapes map to control codes; anything else stands for itself.
  function automatic logic [7:0] esc_map(logic [7:0] u);
    logic [7:0] m;
    case (u)
      8'h41:        m = 8'd7;
      8'h42:        m = 8'd8;
      8'h46:        m = 8'd12;
      8'h4C, 8'h4E: m = 8'd10;
      8'h52:        m = 8'd13;
      8'h54:        m = 8'd9;
      8'h56:        m = 8'd11;
      default:      m = u;
    endcase
    return m;
  endfunction

  function automatic pass_t put_res(pass_t p, kind_e k, logic [7:0] ch, logic t);
    pass_t q;
    q = p;
    q.r[q.n[0]] = '{kind: k, char_value: ch, truncated: t};
    q.n = q.n + 2'd1;
    return q;
  endfunction

  // Add one string character, or cut the string when it is full.
  function automatic pass_t str_put(pass_t p, logic [7:0] ch);
    pass_t q;
    q = p;
    if (q.st.len >= LenLimit) begin
      q = put_res(q, K_SEND, 8'h00, 1'b1);
      q.st.mode = M_IDLE;
      q.st.len = '0;
    end else begin
      q = put_res(q, K_SCHAR, ch, 1'b0);
      q.st.len = q.st.len + LenW'(1);
      q.st.mode = M_STRING;
    end
    return q;
  endfunction

  // Lex one byte in the current mode.
  function automatic pass_t lex_pass(lex_st_t s, logic [7:0] c, logic [7:0] cmt, logic dos);
    pass_t      p;
    cls_e       k;
    logic [7:0] u;
    logic [3:0] d;
    logic [1:0] dig;
    p = '0;
    p.st = s;
    k = byte_class(c);
    u = upcase(c);
    d = (u <= CH_NINE) ? u[3:0] : u[3:0] + 4'd9;
    dig = s.esc_dig + 2'd1;
    case (s.mode)
      M_IDLE: begin
        if (cmt != 8'h00 && c == cmt) begin
          p.st.mode = M_COMMENT;
        end else if (k == C_QUOTE) begin
          p.st.mode = M_STRING;
          p.st.quote = c;
          p.st.len = '0;
        end else if (k == C_BREAK) begin
          p = put_res(p, K_TCHAR, c, 1'b0);
          p = put_res(p, K_TEND, 8'h00, 1'b0);
        end else if (k == C_TOKEN) begin
          p = put_res(p, K_TCHAR, c, 1'b0);
          p.st.mode = M_TOKEN;
          p.st.len = LenW'(1);
        end
      end
      M_COMMENT: begin
        if (c == CH_LF) p.st.mode = M_IDLE;
      end
      M_TOKEN: begin
        if (k == C_TOKEN) begin
          // A full token is cut and the byte opens the next one.
          if (p.st.len >= LenLimit) begin
            p = put_res(p, K_TEND, 8'h00, 1'b1);
            p.st.len = '0;
          end
          p = put_res(p, K_TCHAR, c, 1'b0);
          p.st.len = p.st.len + LenW'(1);
        end else if (k != C_FLUSH) begin
          p = put_res(p, K_TEND, 8'h00, 1'b0);
          p.st.mode = M_IDLE;
          p.st.len = '0;
          p.again = 1'b1;
        end
      end
      M_STRING: begin
        if (c == CH_BSLASH) begin
          p.st.mode = M_ESC;
        end else if (c == s.quote) begin
          p = put_res(p, K_SEND, 8'h00, 1'b0);
          p.st.mode = M_IDLE;
          p.st.len = '0;
        end else if (c != CH_CR && c != CH_LF) begin
          p = str_put(p, c);
        end
      end
      M_ESC: begin
        if (u == CH_CR) begin
          p.st.mode = dos ? M_SKIP : M_STRING;
        end else if (u == CH_LF) begin
          p.st.mode = M_STRING;
        end else if (u == CH_UP_X) begin
          p.st.mode = M_HEX;
          p.st.esc_val = '0;
          p.st.esc_dig = '0;
        end else if (u inside {[CH_ZERO:CH_NINE]}) begin
          p.st.mode = M_OCT;
          p.st.esc_val = '0;
          p.st.esc_dig = '0;
          p.again = 1'b1;
        end else begin
          p = str_put(p, esc_map(u));
        end
      end
      M_HEX: begin
        if (u inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_F]}) begin
          p.st.esc_val = {s.esc_val[3:0], d};
          p.st.esc_dig = dig;
          if (dig == 2'd2) begin
            p.st.esc_dig = '0;
            p = str_put(p, p.st.esc_val);
          end
        end else begin
          // A short escape emits what it has and the byte is lexed again.
          p.st.esc_dig = '0;
          p = str_put(p, s.esc_val);
          p.again = 1'b1;
        end
      end
      M_OCT: begin
        if (c inside {[CH_ZERO:CH_SEVEN]}) begin
          p.st.esc_val = {s.esc_val[4:0], c[2:0]};
          p.st.esc_dig = dig;
          if (dig == 2'd3) begin
            p.st.esc_dig = '0;
            p = str_put(p, p.st.esc_val);
          end
        end else begin
          p.st.esc_dig = '0;
          p = str_put(p, s.esc_val);
          p.again = 1'b1;
        end
      end
      default: begin
        // The byte after a spliced CR is dropped.
        p.st.mode = M_STRING;
      end
    endcase
    return p;
  endfunction

  lex_st_t     st_q, st_d;
  logic [15:0] line_q, line_d;
  logic        ended_q, ended_d;
  logic [7:0]  comment_q;
  logic        dos_q;

  lex_st_t     cur;
  pass_t       p;
  logic        again;
  logic [1:0]  cnt;
  entry_t      ent;
  logic        accept;

  localparam lex_st_t StReset = '{mode: M_IDLE, quote: '0, len: '0, esc_val: '0, esc_dig: '0};

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next lexer state and the results of the current item.
  always_comb begin
    st_d    = st_q;
    line_d  = line_q;
    ended_d = ended_q;
    ent     = '0;
    cnt     = '0;
    cur     = st_q;
    again   = 1'b0;
    p       = '0;
    case (cmd_e'(in_cmd_i))
      CMD_DATA: begin
        if (!ended_q) begin
          if (in_byte_i == CH_LF && line_q != 16'hFFFF) line_d = line_q + 16'd1;
          // At most three passes: a byte can be handed on twice.
          again = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (again) begin
              p = lex_pass(cur, in_byte_i, comment_q, dos_q);
              cur = p.st;
              again = p.again;
              for (int j = 0; j < 2; j++) begin
                if (2'(j) < p.n && cnt != 2'd3) begin
                  ent.res[cnt] = p.r[j];
                  cnt = cnt + 2'd1;
                end
              end
            end
          end
          st_d = cur;
        end
      end
      CMD_END: begin
        if (!ended_q) begin
          p.st = st_q;
          case (st_q.mode)
            M_TOKEN:          p = put_res(p, K_TEND, 8'h00, 1'b0);
            M_STRING, M_SKIP: p = put_res(p, K_SEND, 8'h00, 1'b0);
            M_ESC: begin
              p = str_put(p, CH_BSLASH);
              if (p.st.mode == M_STRING) p = put_res(p, K_SEND, 8'h00, 1'b0);
            end
            M_HEX, M_OCT: begin
              p = str_put(p, st_q.esc_val);
              if (p.st.mode == M_STRING) p = put_res(p, K_SEND, 8'h00, 1'b0);
            end
            default: begin
            end
          endcase
          for (int j = 0; j < 2; j++) begin
            if (2'(j) < p.n) begin
              ent.res[cnt] = p.r[j];
              cnt = cnt + 2'd1;
            end
          end
        end
        ent.res[cnt] = '{kind: K_IEND, char_value: 8'h00, truncated: 1'b0};
        cnt = cnt + 2'd1;
        st_d = StReset;
        ended_d = 1'b1;
      end
      CMD_RESTART: begin
        st_d = StReset;
        line_d = 16'd1;
        ended_d = 1'b0;
      end
      default: begin
      end
    endcase
    ent.count = cnt;
    ent.line_number = line_d;
  end

  assign push_o       = accept && (cnt != 2'd0);
  assign push_entry_o = ent;

  // Lexer state advances on every accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StReset;
      line_q  <= 16'd1;
      ended_q <= 1'b0;
    end else if (accept) begin
      st_q    <= st_d;
      line_q  <= line_d;
      ended_q <= ended_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= 8'h00;
      dos_q     <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_COMMENT_CHAR) comment_q <= cfg_wdata_i;
      if (cfg_addr_i == REG_DOS_LINE_ENDS) dos_q <= cfg_wdata_i[0];
    end
  end

endmodule

// ===== rtl/core/bst_queue.sv =====
module bst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bst_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bst_pkg::entry_t head_o
);
  import bst_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  entry_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o  = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) count_q <= count_q + (PtrW+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PtrW+1)'(1);
    end
  end

endmodule

// ===== rtl/core/bst_emitter.sv =====
module bst_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  bst_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [31:0]     m_axis_tdata,
  output logic [2:0]      m_axis_tuser,
  output logic            m_axis_tlast
);
  import bst_pkg::*;

  logic [1:0] sub_q;
  res_t       sel;
  logic       at_end;
  logic       xfer;

  // Walk the results of the head entry one transfer at a time.
  assign sel    = head_i.res[sub_q];
  assign at_end = (sub_q == head_i.count - 2'd1);
  assign xfer   = m_axis_tvalid && m_axis_tready;
  assign pop_o  = xfer && at_end;

  assign m_axis_tvalid = !empty_i;
  assign m_axis_tuser  = sel.kind;
  assign m_axis_tlast  = at_end;
  assign m_axis_tdata  = {7'd0, head_i.line_number, sel.truncated, sel.char_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else if (xfer) begin
      sub_q <= at_end ? 2'd0 : sub_q + 2'd1;
    end
  end

endmodule

// ===== tb/sv/byte_stream_tokenizer_test.sv =====
module byte_stream_tokenizer_test;
  import bst_pkg::*;

  // Longest token or string the lexer keeps before it cuts.
  localparam int unsigned CHAR_LIMIT = MAX_LEN_DEF - 1;
  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [2:0] {
    LM_IDLE, LM_COMMENT, LM_TOKEN, LM_STRING, LM_ESC, LM_HEX, LM_OCT, LM_SKIP
  } lex_mode_e;

  typedef enum logic [2:0] {
    BC_FLUSH, BC_WHITE, BC_QUOTE, BC_BREAK, BC_TOKEN
  } byte_class_e;

  typedef struct {
    kind_e       kind;
    logic [7:0]  char_value;
    logic        truncated;
    logic [15:0] line_number;
    logic        last;
  } lex_result_t;

  // Lexer predictor and the queue of results it expects from the block.
  class lex_scoreboard;
    logic [7:0]  comment_char;
    logic        dos_line_ends;
    lex_mode_e   mode;
    logic [7:0]  open_quote;
    int unsigned length;
    logic [7:0]  esc_value;
    int unsigned esc_digits;
    logic [15:0] line;
    bit          ended;
    lex_result_t step_results[$];
    lex_result_t pending_results[$];
    int unsigned failures;
    int unsigned active_items;

    function new();
      comment_char = 8'd0;
      dos_line_ends = 1'b0;
      failures = 0;
      active_items = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      mode = LM_IDLE;
      open_quote = 8'd0;
      length = 0;
      esc_value = 8'd0;
      esc_digits = 0;
      line = 16'd1;
      ended = 1'b0;
    endfunction

    function void set_config(logic [7:0] cc, logic dos);
      comment_char = cc;
      dos_line_ends = dos;
    endfunction

    static function byte_class_e byte_class(logic [7:0] c);
      logic [6:0] v;
      v = c[6:0];
      if (v == 7'h7F || v < 7'd8 || (v >= 7'd14 && v < 7'd32)) return BC_FLUSH;
      if (v < 7'd14 || v == 7'd32) return BC_WHITE;
      if (v == 7'd34 || v == 7'd39) return BC_QUOTE;
      if (v == 7'd44) return BC_BREAK;
      return BC_TOKEN;
    endfunction

    // One item causes at most MAX_RES results; anything past that is lost.
    function void emit(kind_e kind, logic [7:0] ch, logic trunc);
      if (step_results.size() < MAX_RES)
        step_results.push_back('{kind, ch, trunc, line, 1'b0});
    endfunction

    // Adds a string character, or cuts the string once it is full.
    function void put_string_char(logic [7:0] ch);
      if (length >= CHAR_LIMIT) begin
        emit(K_SEND, 8'd0, 1'b1);
        mode = LM_IDLE;
        length = 0;
        return;
      end
      emit(K_SCHAR, ch, 1'b0);
      length++;
      mode = LM_STRING;
    endfunction

    // Lexes one byte; returns 1 when the same byte must be lexed again.
    function bit lex_byte(logic [7:0] c);
      byte_class_e cls;
      logic [7:0]  u;
      logic [7:0]  digit;
      cls = byte_class(c);
      u = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'd32 : c;
      case (mode)
        LM_IDLE: begin
          if (comment_char != 8'd0 && c == comment_char) begin
            mode = LM_COMMENT;
          end else if (cls == BC_QUOTE) begin
            mode = LM_STRING;
            open_quote = c;
            length = 0;
          end else if (cls == BC_BREAK) begin
            emit(K_TCHAR, c, 1'b0);
            emit(K_TEND, 8'd0, 1'b0);
          end else if (cls == BC_TOKEN) begin
            emit(K_TCHAR, c, 1'b0);
            mode = LM_TOKEN;
            length = 1;
          end
          return 1'b0;
        end
        LM_COMMENT: begin
          if (c == CH_LF) mode = LM_IDLE;
          return 1'b0;
        end
        LM_TOKEN: begin
          if (cls == BC_FLUSH) return 1'b0;
          if (cls == BC_TOKEN) begin
            if (length >= CHAR_LIMIT) begin
              emit(K_TEND, 8'd0, 1'b1);
              length = 0;
            end
            emit(K_TCHAR, c, 1'b0);
            length++;
            return 1'b0;
          end
          emit(K_TEND, 8'd0, 1'b0);
          mode = LM_IDLE;
          length = 0;
          return 1'b1;
        end
        LM_STRING: begin
          if (c == CH_BSLASH) begin
            mode = LM_ESC;
          end else if (c == open_quote) begin
            emit(K_SEND, 8'd0, 1'b0);
            mode = LM_IDLE;
            length = 0;
          end else if (c != CH_CR && c != CH_LF) begin
            put_string_char(c);
          end
          return 1'b0;
        end
        LM_ESC: begin
          if (u == CH_CR) begin
            mode = dos_line_ends ? LM_SKIP : LM_STRING;
            return 1'b0;
          end
          if (u == CH_LF) begin
            mode = LM_STRING;
            return 1'b0;
          end
          if (u == CH_UP_X) begin
            mode = LM_HEX;
            esc_value = 8'd0;
            esc_digits = 0;
            return 1'b0;
          end
          if (u >= CH_ZERO && u <= CH_NINE) begin
            mode = LM_OCT;
            esc_value = 8'd0;
            esc_digits = 0;
            return 1'b1;
          end
          case (u)
            "A": u = 8'd7;
            "B": u = 8'd8;
            "F": u = 8'd12;
            "L", "N": u = 8'd10;
            "R": u = 8'd13;
            "T": u = 8'd9;
            "V": u = 8'd11;
            default: ;
          endcase
          put_string_char(u);
          return 1'b0;
        end
        LM_HEX: begin
          if ((u >= CH_ZERO && u <= CH_NINE) || (u >= CH_UP_A && u <= CH_UP_F)) begin
            digit = (u <= CH_NINE) ? u - CH_ZERO : u - CH_UP_A + 8'd10;
            esc_value = {esc_value[3:0], digit[3:0]};
            esc_digits++;
            if (esc_digits >= 2) begin
              esc_digits = 0;
              put_string_char(esc_value);
            end
            return 1'b0;
          end
          // A short hex escape gives its value and the byte is lexed again.
          esc_digits = 0;
          put_string_char(esc_value);
          return 1'b1;
        end
        LM_OCT: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            esc_value = {esc_value[4:0], c[2:0]};
            esc_digits++;
            if (esc_digits >= 3) begin
              esc_digits = 0;
              put_string_char(esc_value);
            end
            return 1'b0;
          end
          esc_digits = 0;
          put_string_char(esc_value);
          return 1'b1;
        end
        default: begin
          // The byte after an escaped CR is thrown away in DOS mode.
          mode = LM_STRING;
          return 1'b0;
        end
      endcase
    endfunction

    // End of input closes what is open and reports the end; it stays ended.
    function void end_input();
      if (!ended) begin
        case (mode)
          LM_TOKEN: emit(K_TEND, 8'd0, 1'b0);
          LM_STRING, LM_SKIP: emit(K_SEND, 8'd0, 1'b0);
          LM_ESC, LM_HEX, LM_OCT: begin
            put_string_char(mode == LM_ESC ? CH_BSLASH : esc_value);
            if (mode == LM_STRING) emit(K_SEND, 8'd0, 1'b0);
          end
          default: ;
        endcase
      end
      mode = LM_IDLE;
      open_quote = 8'd0;
      length = 0;
      esc_value = 8'd0;
      esc_digits = 0;
      ended = 1'b1;
      emit(K_IEND, 8'd0, 1'b0);
    endfunction

    // Called for every accepted input transfer.
    function void note_input(cmd_e cmd, logic [7:0] b);
      int unsigned guard;
      step_results.delete();
      case (cmd)
        CMD_DATA: begin
          if (!ended) begin
            active_items++;
            if (b == CH_LF && line != 16'hFFFF) line++;
            guard = 0;
            while (lex_byte(b) && guard < 4) guard++;
          end
        end
        CMD_END: begin
          active_items++;
          end_input();
        end
        CMD_RESTART: begin
          active_items++;
          restart_stream();
        end
        default: ;
      endcase
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    endfunction

    // Called for every accepted output transfer.
    function void check_result(kind_e kind, logic [7:0] ch, logic trunc,
                               logic [15:0] ln, logic last);
      lex_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d char %02h", kind, ch);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        failures++;
      end
      if (ch !== want.char_value) begin
        $error("char_value: expected %02h, actual %02h", want.char_value, ch);
        failures++;
      end
      if (trunc !== want.truncated) begin
        $error("truncated: expected %0b, actual %0b", want.truncated, trunc);
        failures++;
      end
      if (ln !== want.line_number) begin
        $error("line_number: expected %0d, actual %0d", want.line_number, ln);
        failures++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [1:0]  s_axis_tuser = CMD_DATA;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lex_scoreboard lex_sb = new();
  logic [7:0]  cur_comment = 8'd0;
  logic        cur_dos = 1'b0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned cycle_count = 0;

  byte_stream_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Stop a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("byte_stream_tokenizer test failed");
      $finish;
    end
  end

  // Output side: random stalls, every accepted transfer checked in order.
  initial begin : drain
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      lex_sb.check_result(kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[8],
                          m_axis_tdata[24:9], m_axis_tlast);
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
    end
  end

  // Offers one item after a random gap and waits for its transfer.
  task automatic send_item(cmd_e cmd, logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= cmd;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    lex_sb.note_input(cmd, b);
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
  endtask

  function automatic logic [7:0] pick_byte(byte_class_e cls);
    logic [7:0] b;
    do b = 8'($urandom); while (lex_scoreboard::byte_class(b) != cls);
    return b;
  endfunction

  // A string byte that neither escapes nor closes; optionally never CR or LF.
  function automatic logic [7:0] plain_string_byte(logic [7:0] q, bit counted);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_BSLASH || b == q || (counted && (b == CH_CR || b == CH_LF)));
    return b;
  endfunction

  function automatic logic [7:0] hex_digit();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // Two register writes on back-to-back cycles while the block is idle.
  task automatic set_config(logic [7:0] cc, logic dos);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_COMMENT_CHAR;
    cfg_wdata_i <= cc;
    @(posedge clk_i);
    cfg_addr_i <= REG_DOS_LINE_ENDS;
    cfg_wdata_i <= {7'd0, dos};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lex_sb.set_config(cc, dos);
    cur_comment = cc;
    cur_dos = dos;
  endtask

  // Drains every expected result, then lets the block go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lex_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // End of input, some ignored data, maybe a second end, and usually a restart.
  task automatic close_stream();
    send_item(CMD_END, 8'($urandom));
    repeat ($urandom_range(0, 2)) send_item(CMD_DATA, 8'($urandom));
    if ($urandom_range(0, 2) == 0) send_item(CMD_END, 8'($urandom));
    if ($urandom_range(0, 6) != 0) send_item(CMD_RESTART, 8'($urandom));
  endtask

  // Backslash and one random escape form.
  task automatic send_escape(logic [7:0] q);
    string letters;
    letters = "abflnrtvABFLNRTV";
    send_item(CMD_DATA, CH_BSLASH);
    case ($urandom_range(0, 8))
      0: send_item(CMD_DATA, CH_LF);
      1: begin
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, plain_string_byte(q, 1'b0));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: send_item(CMD_DATA, 8'h22);
          1: send_item(CMD_DATA, 8'h27);
          default: send_item(CMD_DATA, CH_BSLASH);
        endcase
      end
      3: send_item(CMD_DATA, letters[$urandom_range(0, 15)]);
      4, 5: begin
        send_item(CMD_DATA, $urandom_range(0, 1) ? CH_UP_X : 8'h78);
        repeat ($urandom_range(0, 2)) send_item(CMD_DATA, hex_digit());
      end
      6, 7: begin
        send_item(CMD_DATA, CH_ZERO + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 3)) send_item(CMD_DATA, CH_ZERO + 8'($urandom_range(0, 7)));
      end
      default: send_item(CMD_DATA, 8'($urandom));
    endcase
  endtask

  // One lexical unit with random content, or some noise.
  task automatic send_segment();
    int unsigned r;
    logic [7:0]  q;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      repeat ($urandom_range(1, 8)) begin
        send_item(CMD_DATA, pick_byte(BC_TOKEN));
        if ($urandom_range(0, 6) == 0) send_item(CMD_DATA, pick_byte(BC_FLUSH));
      end
    end else if (r < 55) begin
      q = pick_byte(BC_QUOTE);
      send_item(CMD_DATA, q);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 2) == 0) send_escape(q);
        else send_item(CMD_DATA, plain_string_byte(q, 1'b0));
      end
      case ($urandom_range(0, 9))
        8: close_stream();
        9: begin
          // Input ends while an escape is still open.
          send_item(CMD_DATA, CH_BSLASH);
          case ($urandom_range(0, 2))
            1: begin
              send_item(CMD_DATA, CH_UP_X);
              send_item(CMD_DATA, hex_digit());
            end
            2: send_item(CMD_DATA, CH_ZERO + 8'($urandom_range(1, 7)));
            default: ;
          endcase
          close_stream();
        end
        default: send_item(CMD_DATA, q);
      endcase
    end else if (r < 65) begin
      repeat ($urandom_range(1, 3)) send_item(CMD_DATA, pick_byte(BC_WHITE));
    end else if (r < 72) begin
      send_item(CMD_DATA, pick_byte(BC_BREAK));
    end else if (r < 78) begin
      if (cur_comment != 8'd0) send_item(CMD_DATA, cur_comment);
      repeat ($urandom_range(0, 4)) send_item(CMD_DATA, 8'($urandom));
      send_item(CMD_DATA, CH_LF);
    end else if (r < 86) begin
      repeat ($urandom_range(1, 4)) send_item(CMD_DATA, 8'($urandom));
    end else if (r < 91) begin
      close_stream();
    end else if (r < 94) begin
      send_item(CMD_RESTART, 8'($urandom));
    end else if (r < 97) begin
      send_item(CMD_NOP, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) send_item(CMD_DATA, CH_LF);
    end
  endtask

  task automatic run_random(int unsigned target);
    int unsigned start;
    start = lex_sb.active_items;
    while (lex_sb.active_items - start < target) send_segment();
    send_item(CMD_RESTART, 8'($urandom));
  endtask

  // Opens a string and fills it with n counted characters.
  task automatic send_long_string(int unsigned n, logic [7:0] q);
    send_item(CMD_DATA, q);
    repeat (n) send_item(CMD_DATA, plain_string_byte(q, 1'b1));
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_config("#", 1'b1);

    // Directed: field extremes, the three-result item, short numeric escapes,
    // DOS splice, comments, end inside an escape, sticky end, no-op command.
    send_item(CMD_DATA, 8'h21);
    send_item(CMD_DATA, 8'hFE);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, ",");
    send_item(CMD_DATA, "A");
    send_item(CMD_DATA, 8'h22);
    send_item(CMD_DATA, "h");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "x");
    send_item(CMD_DATA, "4");
    send_item(CMD_DATA, "g");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "9");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_DATA, "Z");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "n");
    send_item(CMD_DATA, 8'hA2);
    send_item(CMD_DATA, 8'h22);
    send_item(CMD_DATA, "#");
    send_item(CMD_DATA, "z");
    send_item(CMD_DATA, CH_LF);
    send_item(CMD_DATA, 8'h27);
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_END, 8'hFF);
    send_item(CMD_DATA, "q");
    send_item(CMD_END, 8'h00);
    send_item(CMD_NOP, 8'hFF);
    send_item(CMD_RESTART, 8'h00);
    settle();

    // Random phases over several register settings, extremes among them.
    set_config(";", 1'b0);
    run_random(40);
    settle();
    set_config(8'hFF, 1'b1);
    run_random(40);
    settle();
    set_config(8'h00, 1'b0);
    run_random(40);
    settle();
    set_config(8'h80, 1'b1);
    run_random(40);
    settle();

    // Length limit: escapes fill a string to the cut, then input ends on a full string.
    set_config(8'h00, 1'b0);
    send_long_string(CHAR_LIMIT - 2, 8'h27);
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "x");
    send_item(CMD_DATA, "4");
    send_item(CMD_DATA, "1");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "1");
    send_item(CMD_DATA, "0");
    send_item(CMD_DATA, "1");
    send_item(CMD_DATA, CH_BSLASH);
    send_item(CMD_DATA, "x");
    send_item(CMD_DATA, "4");
    send_item(CMD_END, 8'h00);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_DATA, "k");
    send_item(CMD_END, 8'h00);
    settle();

    if (lex_sb.failures == 0 && lex_sb.pending() == 0) begin
      $display("byte_stream_tokenizer test passed");
    end else begin
      $display("byte_stream_tokenizer test failed");
    end
    $finish;
  end

endmodule

// ===== byte_stream_tokenizer.f =====
rtl/core/bst_pkg.sv
rtl/core/bst_lexer.sv
rtl/core/bst_queue.sv
rtl/core/bst_emitter.sv
rtl/core/byte_stream_tokenizer.sv
tb/sv/byte_stream_tokenizer_test.sv
